[design/lctc_pkg.sv]
package lctc_pkg;

    localparam int WeightW = 16;
    localparam int CellW   = 15;
    localparam int TickW   = 32;
    localparam int SumW    = 17;
    localparam int DiffW   = 18;
    localparam int MagW    = 16;
    localparam int StepW   = 11;
    localparam int ProdW   = StepW + MagW;
    localparam int DivW    = 21;
    localparam int QuotW   = 8;
    localparam int CntW    = 3;
    localparam int DelayW  = 16;
    localparam int ThrW    = 17;
    localparam int CfgW    = 17;
    localparam int CfgIdxW = 3;
    localparam int InDataW = 96;
    localparam int OutDataW = 24;
    localparam int QDepth  = 4;
    localparam int QPtrW   = 2;
    localparam int QCntW   = 3;

    localparam logic [7:0] FRAME_TARE  = 8'd87;
    localparam logic [7:0] FRAME_READY = 8'd89;
    localparam logic [7:0] TILT_LIMIT  = 8'd127;
    localparam logic [2:0] LAST_CELL   = 3'd4;

    localparam logic [CfgIdxW-1:0] REG_LOWER_DEAD_ZONE  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_UPPER_DEAD_ZONE  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_PLAY_THRESHOLD   = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_MOVE_THRESHOLD   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_TARE_THRESHOLD   = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_PLAY_DELAY_MS    = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_TARE_DELAY_MS    = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_STEP_NORM_TENTHS = 3'd7;

    typedef enum logic [1:0] {
        MODE_TARE  = 2'd0,
        MODE_READY = 2'd1,
        MODE_PLAY  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        CMD_READY = 2'd0,
        CMD_ZERO  = 2'd1,
        CMD_TILT  = 2'd2,
        CMD_CALIB = 2'd3
    } cmd_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_MUL  = 2'd1,
        BK_DIV  = 2'd2,
        BK_SEND = 2'd3
    } back_state_t;

    typedef struct packed {
        cmd_kind_t                kind;
        logic [SumW-1:0]          sum;
        logic signed [DiffW-1:0]  pitch_diff;
        logic signed [DiffW-1:0]  roll_diff;
    } cmd_t;

    typedef struct packed {
        logic [CellW-1:0]  lower_dead_zone;
        logic [CellW-1:0]  upper_dead_zone;
        logic [ThrW-1:0]   play_threshold;
        logic [ThrW-1:0]   move_threshold;
        logic [ThrW-1:0]   tare_threshold;
        logic [DelayW-1:0] play_delay_ms;
        logic [DelayW-1:0] tare_delay_ms;
        logic [StepW-1:0]  step_norm_tenths;
    } cfg_t;

endpackage

[design/lctc_front.sv]
module lctc_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [lctc_pkg::InDataW-1:0] s_tdata,
    input  lctc_pkg::cfg_t               cfg,
    input  logic                         q_full,
    output logic                         push,
    output lctc_pkg::cmd_t               push_cmd
);
    import lctc_pkg::*;

    mode_t              mode_reg, mode_next;
    logic [TickW-1:0]   play_start_reg, play_start_next;
    logic               play_run_reg, play_run_next;
    logic [TickW-1:0]   tare_start_reg, tare_start_next;
    logic               tare_run_reg, tare_run_next;

    logic signed [WeightW-1:0] w_raw [4];
    logic [CellW-1:0]          w_ok [4];
    logic [SumW-1:0]           sum;
    logic [DiffW-1:0]          pitch_diff;
    logic [DiffW-1:0]          roll_diff;
    logic [TickW-1:0]          tick;
    logic [TickW-1:0]          play_elapsed;
    logic [TickW-1:0]          tare_elapsed;
    logic                      accept;
    cmd_kind_t                 kind;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign tick     = s_tdata[InDataW-1 -: TickW];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_raw[i] = s_tdata[WeightW*i +: WeightW];
            if (w_raw[i] < $signed({1'b0, cfg.lower_dead_zone}) ||
                w_raw[i] > $signed({1'b0, cfg.upper_dead_zone})) begin
                w_ok[i] = '0;
            end else begin
                w_ok[i] = w_raw[i][CellW-1:0];
            end
        end
    end

    assign sum = {2'b00, w_ok[0]} + {2'b00, w_ok[1]} + {2'b00, w_ok[2]} + {2'b00, w_ok[3]};
    assign pitch_diff = {3'b000, w_ok[0]} + {3'b000, w_ok[3]}
                      - {3'b000, w_ok[1]} - {3'b000, w_ok[2]};
    assign roll_diff  = {3'b000, w_ok[0]} + {3'b000, w_ok[1]}
                      - {3'b000, w_ok[2]} - {3'b000, w_ok[3]};
    assign play_elapsed = tick - play_start_reg;
    assign tare_elapsed = tick - tare_start_reg;

    always_comb begin
        mode_next       = mode_reg;
        play_start_next = play_start_reg;
        play_run_next   = play_run_reg;
        tare_start_next = tare_start_reg;
        tare_run_next   = tare_run_reg;
        kind            = CMD_READY;
        case (mode_reg)
            MODE_TARE: begin
                kind      = CMD_CALIB;
                mode_next = MODE_READY;
            end
            MODE_PLAY: begin
                if (sum > cfg.move_threshold && sum != '0) begin
                    kind          = CMD_TILT;
                    tare_run_next = 1'b0;
                end else begin
                    kind = CMD_ZERO;
                end
                if (sum <= cfg.tare_threshold) begin
                    if (!tare_run_next) begin
                        tare_start_next = tick;
                        tare_run_next   = 1'b1;
                    end else if (tare_elapsed >= {16'b0, cfg.tare_delay_ms}) begin
                        mode_next     = MODE_TARE;
                        tare_run_next = 1'b0;
                    end
                end else begin
                    tare_run_next = 1'b0;
                end
            end
            default: begin
                kind = CMD_READY;
                if (sum > cfg.play_threshold) begin
                    if (!play_run_reg) begin
                        play_start_next = tick;
                        play_run_next   = 1'b1;
                    end else if (play_elapsed >= {16'b0, cfg.play_delay_ms}) begin
                        mode_next     = MODE_PLAY;
                        play_run_next = 1'b0;
                    end
                end else begin
                    play_run_next = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_READY;
            play_start_reg <= '0;
            play_run_reg   <= 1'b0;
            tare_start_reg <= '0;
            tare_run_reg   <= 1'b0;
        end else if (accept) begin
            mode_reg       <= mode_next;
            play_start_reg <= play_start_next;
            play_run_reg   <= play_run_next;
            tare_start_reg <= tare_start_next;
            tare_run_reg   <= tare_run_next;
        end
    end

    assign push                = accept;
    assign push_cmd.kind       = kind;
    assign push_cmd.sum        = sum;
    assign push_cmd.pitch_diff = pitch_diff;
    assign push_cmd.roll_diff  = roll_diff;

`ifndef SYNTHESIS
    a_tare_returns_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && mode_reg == MODE_TARE) |=> (mode_reg == MODE_READY))
        else $error("tare sample did not return the mode to ready");
`endif

endmodule

[design/lctc_cmd_queue.sv]
module lctc_cmd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  lctc_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output lctc_pkg::cmd_t pop_cmd,
    output logic           empty
);
    import lctc_pkg::*;

    cmd_t              entry_reg [QDepth];
    logic [QPtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCntW-1:0]  count_reg, count_next;

    assign full    = (count_reg == QCntW'(QDepth));
    assign empty   = (count_reg == '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCntW'(push) - QCntW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("command pushed into a full queue");
`endif

endmodule

[design/lctc_back.sv]
module lctc_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          empty,
    output logic                          pop,
    input  lctc_pkg::cmd_t                pop_cmd,
    input  logic [lctc_pkg::StepW-1:0]    tilt_scale,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lctc_pkg::OutDataW-1:0] m_tdata,
    output logic                          m_tlast
);
    import lctc_pkg::*;

    back_state_t              state_reg, state_next;
    cmd_kind_t                kind_reg, kind_next;
    logic [DivW-1:0]          divisor_reg, divisor_next;
    logic signed [DiffW-1:0]  pdiff_reg, pdiff_next;
    logic signed [DiffW-1:0]  rdiff_reg, rdiff_next;
    logic                     sel_reg, sel_next;
    logic                     neg_reg, neg_next;
    logic [ProdW-1:0]         rem_reg, rem_next;
    logic [CntW-1:0]          cnt_reg, cnt_next;
    logic [QuotW-1:0]         q_reg, q_next;
    logic [7:0]               pitch_reg, pitch_next;
    logic [7:0]               roll_reg, roll_next;
    logic [2:0]               cell_reg, cell_next;

    logic signed [DiffW-1:0]  diff;
    logic [DiffW-1:0]         mag;
    logic [ProdW:0]           trial;
    logic                     ge;
    logic [QuotW-1:0]         q_sat;
    logic [7:0]               q_signed;
    logic [7:0]               first_byte;
    logic [7:0]               second_byte;
    logic [2:0]               tare_cell;

    always_comb begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        divisor_next = divisor_reg;
        pdiff_next   = pdiff_reg;
        rdiff_next   = rdiff_reg;
        sel_next     = sel_reg;
        neg_next     = neg_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        q_next       = q_reg;
        pitch_next   = pitch_reg;
        roll_next    = roll_reg;
        cell_next    = cell_reg;
        diff         = sel_reg ? rdiff_reg : pdiff_reg;
        mag          = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
        trial        = {7'b0, divisor_reg} << cnt_reg;
        ge           = {1'b0, rem_reg} >= trial;
        q_sat        = '0;
        q_signed     = '0;
        case (state_reg)
            BK_IDLE: begin
                if (!empty) begin
                    kind_next    = pop_cmd.kind;
                    divisor_next = ({4'b0, pop_cmd.sum} << 3) + ({4'b0, pop_cmd.sum} << 1);
                    pdiff_next   = pop_cmd.pitch_diff;
                    rdiff_next   = pop_cmd.roll_diff;
                    sel_next     = 1'b0;
                    cell_next    = 3'd1;
                    state_next   = (pop_cmd.kind == CMD_TILT) ? BK_MUL : BK_SEND;
                end
            end
            BK_MUL: begin
                neg_next   = diff[DiffW-1];
                rem_next   = ProdW'(tilt_scale) * ProdW'(mag[MagW-1:0]);
                q_next     = '0;
                cnt_next   = CntW'(QuotW - 1);
                state_next = BK_DIV;
            end
            BK_DIV: begin
                if (ge) begin
                    rem_next = rem_reg - trial[ProdW-1:0];
                end
                q_next = {q_reg[QuotW-2:0], ge};
                if (cnt_reg == '0) begin
                    q_sat    = (q_next > TILT_LIMIT) ? TILT_LIMIT : q_next;
                    q_signed = neg_reg ? 8'(-q_sat) : q_sat;
                    if (!sel_reg) begin
                        pitch_next = q_signed;
                        sel_next   = 1'b1;
                        state_next = BK_MUL;
                    end else begin
                        roll_next  = q_signed;
                        state_next = BK_SEND;
                    end
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            BK_SEND: begin
                if (m_tready) begin
                    if (kind_reg == CMD_CALIB && cell_reg != LAST_CELL) begin
                        cell_next = cell_reg + 1'b1;
                    end else begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        pop         = (state_reg == BK_IDLE) && !empty;
        m_tvalid    = (state_reg == BK_SEND);
        first_byte  = FRAME_READY;
        second_byte = FRAME_READY;
        tare_cell   = '0;
        m_tlast     = 1'b1;
        case (kind_reg)
            CMD_READY: begin
                first_byte  = FRAME_READY;
                second_byte = FRAME_READY;
            end
            CMD_ZERO: begin
                first_byte  = '0;
                second_byte = '0;
            end
            CMD_TILT: begin
                first_byte  = pitch_reg;
                second_byte = roll_reg;
            end
            CMD_CALIB: begin
                first_byte  = FRAME_TARE;
                second_byte = FRAME_TARE;
                tare_cell   = cell_reg;
                m_tlast     = (cell_reg == LAST_CELL);
            end
            default: begin
                first_byte  = FRAME_READY;
                second_byte = FRAME_READY;
            end
        endcase
        m_tdata = {5'b0, tare_cell, second_byte, first_byte};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        divisor_reg <= divisor_next;
        pdiff_reg   <= pdiff_next;
        rdiff_reg   <= rdiff_next;
        sel_reg     <= sel_next;
        neg_reg     <= neg_next;
        rem_reg     <= rem_next;
        cnt_reg     <= cnt_next;
        q_reg       <= q_next;
        pitch_reg   <= pitch_next;
        roll_reg    <= roll_next;
        cell_reg    <= cell_next;
    end

`ifndef SYNTHESIS
    a_single_frame_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_SEND && kind_reg != CMD_CALIB) |-> m_tlast)
        else $error("single-frame command sent without last");
    a_div_runs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_DIV && cnt_reg != '0) |=> (state_reg == BK_DIV))
        else $error("division left before all quotient bits");
    a_pop_starts_work: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (state_reg != BK_IDLE))
        else $error("popped command was not taken up");
`endif

endmodule

[design/load_cell_tilt_controller_core.sv]
// Load-cell tilt controller. Each input beat on the s_ channel is one sample of four
// signed cell weights and a millisecond tick. Each sample causes one result frame, or
// four frames when the block is in tare mode; the final frame of a sample has m_tlast set.
// Frames carry pitch and roll, 0,0, 89,89 for ready, or 87,87 with a cell number to tare.
// Registers are written through the cfg_ channel, which is always ready; write them only
// while the block is idle.
// The front end classifies a sample and runs the mode machine in the cycle it is accepted,
// then places a command in a four-entry queue. s_tready drops only when that queue is full.
// The back end computes pitch and roll with one multiplier and an eight-step restoring
// divider, each axis passing through the multiply and divide states, pitch before roll;
// it pops no new command until the current one has been sent.
// Ready and zero frames skip the multiplier and divider; tare frames go out one per beat.
// A stalled receiver holds the current frame; the front keeps accepting until the queue fills.
// Reset (aresetn low, synchronous) restores all registers to their defaults, enters ready
// mode, stops both timers and empties the queue. There is no clearing pass.
module load_cell_tilt_controller_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // weight_one, weight_two, weight_three, weight_four, tick_ms
    input  logic [lctc_pkg::InDataW-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // first_byte, second_byte, tare_cell, zero fill
    output logic [lctc_pkg::OutDataW-1:0] m_tdata,
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lctc_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [lctc_pkg::CfgW-1:0]     cfg_data
);
    import lctc_pkg::*;

    cfg_t  cfg_reg;
    logic  q_full;
    logic  q_empty;
    logic  push;
    logic  pop;
    cmd_t  push_cmd;
    cmd_t  pop_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lower_dead_zone  <= 15'd8;
            cfg_reg.upper_dead_zone  <= 15'd8000;
            cfg_reg.play_threshold   <= 17'd160;
            cfg_reg.move_threshold   <= 17'd80;
            cfg_reg.tare_threshold   <= 17'd8;
            cfg_reg.play_delay_ms    <= 16'd1000;
            cfg_reg.tare_delay_ms    <= 16'd2000;
            cfg_reg.step_norm_tenths <= 11'd701;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_LOWER_DEAD_ZONE:  cfg_reg.lower_dead_zone  <= cfg_data[CellW-1:0];
                REG_UPPER_DEAD_ZONE:  cfg_reg.upper_dead_zone  <= cfg_data[CellW-1:0];
                REG_PLAY_THRESHOLD:   cfg_reg.play_threshold   <= cfg_data[ThrW-1:0];
                REG_MOVE_THRESHOLD:   cfg_reg.move_threshold   <= cfg_data[ThrW-1:0];
                REG_TARE_THRESHOLD:   cfg_reg.tare_threshold   <= cfg_data[ThrW-1:0];
                REG_PLAY_DELAY_MS:    cfg_reg.play_delay_ms    <= cfg_data[DelayW-1:0];
                REG_TARE_DELAY_MS:    cfg_reg.tare_delay_ms    <= cfg_data[DelayW-1:0];
                REG_STEP_NORM_TENTHS: cfg_reg.step_norm_tenths <= cfg_data[StepW-1:0];
                default: begin
                end
            endcase
        end
    end

    lctc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    lctc_cmd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    lctc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .empty      (q_empty),
        .pop        (pop),
        .pop_cmd    (pop_cmd),
        .tilt_scale (cfg_reg.step_norm_tenths),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

[tb/tb.sv]
module tb;
    import lctc_pkg::*;

    localparam int QuietLimit = 3000;

    typedef enum {
        LOAD_FULL,
        LOAD_LIGHT,
        LOAD_EMPTY,
        LOAD_NOISE
    } load_kind_t;

    typedef struct {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [2:0] tare_cell;
        logic       last_flag;
    } tilt_frame_t;

    class tilt_scoreboard;
        cfg_t          regs;
        mode_t         mode;
        logic [31:0]   play_start;
        logic [31:0]   tare_start;
        bit            play_running;
        bit            tare_running;
        tilt_frame_t   frames_due[$];
        int            errors;

        function new();
            regs.lower_dead_zone  = 8;
            regs.upper_dead_zone  = 8000;
            regs.play_threshold   = 160;
            regs.move_threshold   = 80;
            regs.tare_threshold   = 8;
            regs.play_delay_ms    = 1000;
            regs.tare_delay_ms    = 2000;
            regs.step_norm_tenths = 701;
            mode = MODE_READY;
            play_start = '0;
            tare_start = '0;
            play_running = 0;
            tare_running = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] value);
            case (idx)
                REG_LOWER_DEAD_ZONE:  regs.lower_dead_zone  = value[CellW-1:0];
                REG_UPPER_DEAD_ZONE:  regs.upper_dead_zone  = value[CellW-1:0];
                REG_PLAY_THRESHOLD:   regs.play_threshold   = value[ThrW-1:0];
                REG_MOVE_THRESHOLD:   regs.move_threshold   = value[ThrW-1:0];
                REG_TARE_THRESHOLD:   regs.tare_threshold   = value[ThrW-1:0];
                REG_PLAY_DELAY_MS:    regs.play_delay_ms    = value[DelayW-1:0];
                REG_TARE_DELAY_MS:    regs.tare_delay_ms    = value[DelayW-1:0];
                REG_STEP_NORM_TENTHS: regs.step_norm_tenths = value[StepW-1:0];
                default: ;
            endcase
        endfunction

        function int tilt_of(int diff, int total);
            longint q;
            q = (longint'(regs.step_norm_tenths) * diff) / (longint'(10) * total);
            if (q > int'(TILT_LIMIT)) q = int'(TILT_LIMIT);
            if (q < -int'(TILT_LIMIT)) q = -int'(TILT_LIMIT);
            return int'(q);
        endfunction

        function void push_frame(logic [7:0] a, logic [7:0] b, logic [2:0] cell_no, logic fin);
            tilt_frame_t f;
            f.first_byte = a;
            f.second_byte = b;
            f.tare_cell = cell_no;
            f.last_flag = fin;
            frames_due.push_back(f);
        endfunction

        function void note_sample(logic [InDataW-1:0] data);
            int                 w[4];
            int                 total;
            int                 pitch;
            int                 roll;
            int                 slot;
            logic signed [15:0] raw;
            logic [31:0]        now;
            logic [31:0]        elapsed;
            total = 0;
            pitch = 0;
            roll = 0;
            now = data[64 +: TickW];
            for (int i = 0; i < 4; i++) begin
                raw = data[16*i +: 16];
                w[i] = raw;
                if (w[i] < int'(regs.lower_dead_zone) || w[i] > int'(regs.upper_dead_zone))
                    w[i] = 0;
                total += w[i];
            end
            if (total > 0) begin
                pitch = tilt_of((w[0] + w[3]) - (w[1] + w[2]), total);
                roll  = tilt_of((w[0] + w[1]) - (w[2] + w[3]), total);
            end
            case (mode)
                MODE_TARE: begin
                    for (slot = 1; slot <= int'(LAST_CELL); slot++)
                        push_frame(FRAME_TARE, FRAME_TARE, 3'(slot), slot == int'(LAST_CELL));
                    mode = MODE_READY;
                end
                MODE_PLAY: begin
                    if (total > int'(regs.move_threshold) && total > 0) begin
                        push_frame(8'(pitch), 8'(roll), '0, 1'b1);
                        tare_running = 0;
                    end else begin
                        push_frame('0, '0, '0, 1'b1);
                    end
                    if (total <= int'(regs.tare_threshold)) begin
                        elapsed = now - tare_start;
                        if (!tare_running) begin
                            tare_start = now;
                            tare_running = 1;
                        end else if (elapsed >= 32'(regs.tare_delay_ms)) begin
                            mode = MODE_TARE;
                            tare_running = 0;
                        end
                    end else begin
                        tare_running = 0;
                    end
                end
                default: begin
                    push_frame(FRAME_READY, FRAME_READY, '0, 1'b1);
                    if (total > int'(regs.play_threshold)) begin
                        elapsed = now - play_start;
                        if (!play_running) begin
                            play_start = now;
                            play_running = 1;
                        end else if (elapsed >= 32'(regs.play_delay_ms)) begin
                            mode = MODE_PLAY;
                            play_running = 0;
                        end
                    end else begin
                        play_running = 0;
                    end
                end
            endcase
        endfunction

        function void check_frame(logic [OutDataW-1:0] data, logic fin);
            tilt_frame_t want;
            if (frames_due.size() == 0) begin
                $error("unexpected frame %h last %b", data, fin);
                errors++;
                return;
            end
            want = frames_due.pop_front();
            if (data[7:0] !== want.first_byte) begin
                $error("first_byte expected %0d actual %0d",
                       $signed(want.first_byte), $signed(data[7:0]));
                errors++;
            end
            if (data[15:8] !== want.second_byte) begin
                $error("second_byte expected %0d actual %0d",
                       $signed(want.second_byte), $signed(data[15:8]));
                errors++;
            end
            if (data[18:16] !== want.tare_cell) begin
                $error("tare_cell expected %0d actual %0d", want.tare_cell, data[18:16]);
                errors++;
            end
            if (fin !== want.last_flag) begin
                $error("last expected %0d actual %0d", want.last_flag, fin);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [InDataW-1:0]   s_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OutDataW-1:0]  m_tdata;
    logic                 m_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CfgIdxW-1:0]   cfg_index;
    logic [CfgW-1:0]      cfg_data;

    tilt_scoreboard sb = new();

    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_len;
    int           hold_gen;
    logic [31:0]  tick_now;

    load_cell_tilt_controller_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [InDataW-1:0] sample_of(int w1, int w2, int w3, int w4,
                                                     logic [31:0] tick);
        return {tick, 16'(w4), 16'(w3), 16'(w2), 16'(w1)};
    endfunction

    task automatic send_sample(logic [InDataW-1:0] data);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = data;
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(data);
    endtask

    task automatic release_input();
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_drain();
        while (sb.frames_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, value);
    endtask

    task automatic apply_setting(logic [CfgW-1:0] lower, logic [CfgW-1:0] upper,
                                 logic [CfgW-1:0] play_thr, logic [CfgW-1:0] move_thr,
                                 logic [CfgW-1:0] tare_thr, logic [CfgW-1:0] play_dly,
                                 logic [CfgW-1:0] tare_dly, logic [CfgW-1:0] step);
        write_reg(REG_LOWER_DEAD_ZONE, lower);
        write_reg(REG_UPPER_DEAD_ZONE, upper);
        write_reg(REG_PLAY_THRESHOLD, play_thr);
        write_reg(REG_MOVE_THRESHOLD, move_thr);
        write_reg(REG_TARE_THRESHOLD, tare_thr);
        write_reg(REG_PLAY_DELAY_MS, play_dly);
        write_reg(REG_TARE_DELAY_MS, tare_dly);
        write_reg(REG_STEP_NORM_TENTHS, step);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // The receiver owns its long hold count; the main flow only requests one.
    initial begin
        int seen_gen;
        int hold_left;
        seen_gen = 0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_gen != seen_gen) begin
                seen_gen = hold_gen;
                hold_left = hold_len;
            end
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else begin
                m_tready = ($urandom_range(99) >= recv_stall_pct);
            end
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_frame(m_tdata, m_tlast);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QuietLimit) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb failed");
        $finish;
    end

    initial begin
        int                phase;
        int                k;
        int                c;
        int                pick;
        int                left_in_burst;
        int                span;
        int                lo;
        int                hi;
        load_kind_t        kind;
        logic [15:0]       w [4];
        logic [CfgW-1:0]   lower;
        logic [CfgW-1:0]   step;

        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_len = 0;
        hold_gen = 0;
        tick_now = '0;
        left_in_burst = 0;
        kind = LOAD_FULL;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset settings: empty board, dead zones, play entry, tilt both ways, light load,
        // tare entry and its four frames, then a second round across the tick wrap.
        send_sample(sample_of(0, 0, 0, 0, 32'd0));
        send_sample(sample_of(32767, -32768, 7, 8001, 32'd5));
        send_sample(sample_of(-1, 8000, 8, 32767, 32'd10));
        send_sample(sample_of(100, 100, 100, 100, 32'd500));
        send_sample(sample_of(100, 100, 100, 100, 32'd1010));
        send_sample(sample_of(1000, 10, 10, 1000, 32'd1020));
        send_sample(sample_of(10, 1000, 1000, 10, 32'd1030));
        send_sample(sample_of(8000, 8000, 8, 8, 32'd1040));
        send_sample(sample_of(20, 20, 10, 0, 32'd1050));
        send_sample(sample_of(0, 0, 0, 0, 32'd1060));
        send_sample(sample_of(0, 0, 0, 0, 32'd3059));
        send_sample(sample_of(7, 7, 7, 7, 32'd3060));
        send_sample(sample_of(500, 500, 500, 500, 32'd3070));
        send_sample(sample_of(200, 0, 0, 0, 32'hFFFF_FF00));
        send_sample(sample_of(0, 0, 200, 0, 32'h0000_02E8));
        send_sample(sample_of(-32768, -32768, -32768, -32768, 32'hFFFF_FFFF));
        send_sample(sample_of(8, 0, 0, 0, 32'h0000_07CF));
        send_sample(sample_of(0, 0, 0, 0, 32'h0000_07D0));
        release_input();
        wait_drain();

        for (phase = 0; phase < 7; phase++) begin
            case (phase)
                0: apply_setting(8, 8000, 160, 80, 8, 20, 30, 701);
                1: apply_setting(0, 32767, 0, 0, 0, 0, 0, 17'h1FFFF);
                2: apply_setting(17'h1FFFF, 17'h1FFFF, 131071, 131071, 131071,
                                 17'h1FFFF, 17'h1FFFF, 0);
                default: begin
                    lower = 17'($urandom_range(64));
                    if ($urandom_range(1)) step = 17'($urandom);
                    else step = 17'($urandom_range(1270));
                    apply_setting(lower, 17'($urandom_range(32767, lower)),
                                  17'($urandom_range(1000)), 17'($urandom_range(500)),
                                  17'($urandom_range(100)), 17'($urandom_range(200)),
                                  17'($urandom_range(200)), step);
                end
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            if (phase == 4) begin
                hold_len = 300;
                hold_gen++;
            end
            lo = sb.regs.lower_dead_zone;
            hi = sb.regs.upper_dead_zone;
            for (k = 0; k < 42; k++) begin
                if (left_in_burst == 0) begin
                    pick = $urandom_range(99);
                    kind = pick < 45 ? LOAD_FULL : pick < 65 ? LOAD_LIGHT :
                           pick < 90 ? LOAD_EMPTY : LOAD_NOISE;
                    left_in_burst = $urandom_range(8, 1);
                end
                left_in_burst--;
                for (c = 0; c < 4; c++) begin
                    case (kind)
                        LOAD_FULL: w[c] = (lo <= hi) ? 16'($urandom_range(hi, lo))
                                                     : 16'($urandom);
                        LOAD_LIGHT: begin
                            span = (hi > lo + 40) ? 40 : ((hi >= lo) ? hi - lo : 0);
                            w[c] = 16'(lo + $urandom_range(span));
                        end
                        LOAD_EMPTY: begin
                            case ($urandom_range(2))
                                0: w[c] = '0;
                                1: w[c] = {1'b1, 15'($urandom)};
                                default: w[c] = (lo > 0) ? 16'(lo - 1) : '0;
                            endcase
                        end
                        default: w[c] = 16'($urandom);
                    endcase
                end
                pick = $urandom_range(99);
                if (pick < 4)
                    tick_now = $urandom;
                else if (pick < 8)
                    tick_now += $urandom;
                else
                    tick_now += $urandom_range((int'(sb.regs.play_delay_ms) +
                                                int'(sb.regs.tare_delay_ms)) / 3 + 4);
                send_sample({tick_now, w[3], w[2], w[1], w[0]});
            end
            release_input();
            wait_drain();
        end

        repeat (30) @(posedge aclk);
        if (sb.errors == 0 && sb.frames_due.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
